// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker of the execution core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while in reset.
`define BFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define BFE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bfe_pkg.sv
// ---------------------------------------------------------------------------
// bfe_pkg
// Types and constants shared by the front end, back end and top level.
// ---------------------------------------------------------------------------
package bfe_pkg;

  // Width of a program address.
  localparam int unsigned PROG_ADDR_BITS = 12;

  // Command characters.
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // Status codes of a result word.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNMATCHED = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_HALTED    = 2'd3;

  // Decoded command class.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_OUT,
    OP_IN,
    OP_OPEN,
    OP_CLOSE
  } bfe_op_t;

  // Input word.
  typedef struct packed {
    logic [7:0]                instr_char;
    logic [PROG_ADDR_BITS-1:0] instr_addr;
    logic [7:0]                in_byte;
  } bfe_in_t;

  // Result word.
  typedef struct packed {
    logic                      out_valid;
    logic [7:0]                out_byte;
    logic                      jump;
    logic [PROG_ADDR_BITS-1:0] jump_addr;
    logic                      skipping;
    logic [1:0]                status;
  } bfe_out_t;

  // Classified command held in the queue between front and back end.
  typedef struct packed {
    bfe_op_t                   op;
    logic [PROG_ADDR_BITS-1:0] addr;
    logic [7:0]                data;
  } bfe_cmd_t;

  // Control returned from the back end to the front end.
  typedef struct packed {
    logic take;
    logic clearing;
  } bfe_bk_status_t;

endpackage

// File: rtl/bfe_front.sv
// ---------------------------------------------------------------------------
// bfe_front
// Accepts input words, classifies the program character and holds the
// classified commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module bfe_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bfe_pkg::bfe_in_t        in_data,
  output logic                    cmd_valid,
  output bfe_pkg::bfe_cmd_t       cmd,
  input  bfe_pkg::bfe_bk_status_t bk
);
  import bfe_pkg::*;

  localparam logic [1:0] QFULL = 2'd2;

  bfe_cmd_t   q_mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  bfe_op_t    op;

  // Classify the program character.
  always_comb begin
    case (in_data.instr_char)
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NONE;
    endcase
  end

  // Queue handshakes; no word is taken while the tape is being cleared.
  assign in_ready  = (cnt_r != QFULL) && !bk.clearing;
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && bk.take;
  assign cmd       = q_mem[rd_ptr_r];

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{op: op, addr: in_data.instr_addr, data: in_data.in_byte};
    end
  end

endmodule

// File: rtl/bfe_back.sv
// ---------------------------------------------------------------------------
// bfe_back
// Executes classified commands against the tape and loop stack memories and
// places each result word in an output register.
// ---------------------------------------------------------------------------
module bfe_back #(
  parameter int unsigned TAPE_CELLS  = 1024,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  input  bfe_pkg::bfe_cmd_t       cmd,
  output bfe_pkg::bfe_bk_status_t bk,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bfe_pkg::bfe_out_t       out_data
);
  import bfe_pkg::*;

  localparam int unsigned HEAD_W = $clog2(TAPE_CELLS);
  localparam int unsigned SIDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned SCNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_CELLS - 1);
  localparam logic [SCNT_W-1:0] SCNT_FULL = SCNT_W'(STACK_DEPTH);
  localparam logic [SCNT_W-1:0] SCNT_ONE  = SCNT_W'(1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_RUN,
    S_LOAD,
    S_POP
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [HEAD_W-1:0]   head_r;
  logic [HEAD_W-1:0]   head_nxt;
  logic [7:0]          cell_r;
  logic [7:0]          cell_nxt;
  logic [SCNT_W-1:0]   scnt_r;
  logic [SCNT_W-1:0]   scnt_nxt;
  logic [SCNT_W-1:0]   skip_r;
  logic [SCNT_W-1:0]   skip_nxt;
  logic [1:0]          halt_r;
  logic [1:0]          halt_nxt;
  logic [HEAD_W-1:0]   clr_r;
  logic [HEAD_W-1:0]   clr_nxt;
  bfe_out_t            res_r;
  bfe_out_t            res_nxt;
  logic                res_vld_r;
  logic                res_vld_nxt;
  bfe_out_t            res_new;
  logic                pop_wait;
  logic                can_emit;
  logic                take;
  logic [SCNT_W-1:0]   scnt_dec;

  // Tape memory ports.
  logic [7:0]          tape_mem [TAPE_CELLS];
  logic                tape_we;
  logic [HEAD_W-1:0]   tape_waddr;
  logic [7:0]          tape_wdata;
  logic                tape_re;
  logic [HEAD_W-1:0]   tape_raddr;
  logic [7:0]          tape_rdata_r;

  // Loop stack memory ports.
  logic [PROG_ADDR_BITS-1:0] stk_mem [STACK_DEPTH];
  logic                      stk_we;
  logic                      stk_re;
  logic [PROG_ADDR_BITS-1:0] stk_rdata_r;

  assign can_emit    = !res_vld_r || out_ready;
  assign take        = (state_r == S_RUN) && can_emit;
  assign bk.take     = take;
  assign bk.clearing = (state_r == S_CLEAR);
  assign out_valid   = res_vld_r;
  assign out_data    = res_r;
  assign scnt_dec    = scnt_r - SCNT_ONE;

  // Command execution and sequencing.
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    cell_nxt    = cell_r;
    scnt_nxt    = scnt_r;
    skip_nxt    = skip_r;
    halt_nxt    = halt_r;
    clr_nxt     = clr_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !out_ready;
    res_new     = '0;
    pop_wait    = 1'b0;
    tape_we     = 1'b0;
    tape_waddr  = head_r;
    tape_wdata  = cell_r;
    tape_re     = 1'b0;
    tape_raddr  = head_r;
    stk_we      = 1'b0;
    stk_re      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Zero the tape one cell a cycle.
        tape_we    = 1'b1;
        tape_waddr = clr_r;
        tape_wdata = 8'd0;
        clr_nxt    = clr_r + HEAD_W'(1);
        if (clr_r == HEAD_LAST) begin
          state_nxt = S_RUN;
        end
      end
      S_LOAD: begin
        // The cell under the new head arrives from the tape.
        cell_nxt  = tape_rdata_r;
        state_nxt = S_RUN;
      end
      S_POP: begin
        // The popped address arrives from the stack.
        res_new.jump      = 1'b1;
        res_new.jump_addr = stk_rdata_r;
        res_nxt           = res_new;
        res_vld_nxt       = 1'b1;
        state_nxt         = S_RUN;
      end
      S_RUN: begin
        if (cmd_valid && can_emit) begin
          if (halt_r != STAT_OK) begin
            res_new.status = STAT_HALTED;
          end else if (skip_r != '0) begin
            // Skip mode only tracks bracket nesting.
            if (cmd.op == OP_OPEN) begin
              if (skip_r >= SCNT_FULL) begin
                halt_nxt       = STAT_OVERFLOW;
                res_new.status = STAT_OVERFLOW;
              end else begin
                skip_nxt         = skip_r + SCNT_ONE;
                res_new.skipping = 1'b1;
              end
            end else if (cmd.op == OP_CLOSE) begin
              skip_nxt         = skip_r - SCNT_ONE;
              res_new.skipping = (skip_r != SCNT_ONE);
            end else begin
              res_new.skipping = 1'b1;
            end
          end else begin
            case (cmd.op)
              OP_RIGHT, OP_LEFT: begin
                // Write the cached cell back and fetch the next one.
                if (cmd.op == OP_RIGHT) begin
                  head_nxt = (head_r == HEAD_LAST) ? '0 : head_r + HEAD_W'(1);
                end else begin
                  head_nxt = (head_r == '0) ? HEAD_LAST : head_r - HEAD_W'(1);
                end
                tape_we    = 1'b1;
                tape_re    = 1'b1;
                tape_raddr = head_nxt;
                state_nxt  = S_LOAD;
              end
              OP_INC: cell_nxt = cell_r + 8'd1;
              OP_DEC: cell_nxt = cell_r - 8'd1;
              OP_OUT: begin
                res_new.out_valid = 1'b1;
                res_new.out_byte  = cell_r;
              end
              OP_IN: cell_nxt = cmd.data;
              OP_OPEN: begin
                if (cell_r == 8'd0) begin
                  skip_nxt         = SCNT_ONE;
                  res_new.skipping = 1'b1;
                end else if (scnt_r >= SCNT_FULL) begin
                  halt_nxt       = STAT_OVERFLOW;
                  res_new.status = STAT_OVERFLOW;
                end else begin
                  stk_we   = 1'b1;
                  scnt_nxt = scnt_r + SCNT_ONE;
                end
              end
              OP_CLOSE: begin
                if (scnt_r == '0) begin
                  halt_nxt       = STAT_UNMATCHED;
                  res_new.status = STAT_UNMATCHED;
                end else begin
                  stk_re    = 1'b1;
                  scnt_nxt  = scnt_dec;
                  pop_wait  = 1'b1;
                  state_nxt = S_POP;
                end
              end
              default: ;
            endcase
          end
          if (!pop_wait) begin
            res_nxt     = res_new;
            res_vld_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      head_r    <= '0;
      cell_r    <= 8'd0;
      scnt_r    <= '0;
      skip_r    <= '0;
      halt_r    <= STAT_OK;
      clr_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cell_r    <= cell_nxt;
      scnt_r    <= scnt_nxt;
      skip_r    <= skip_nxt;
      halt_r    <= halt_nxt;
      clr_r     <= clr_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Tape memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (tape_re) begin
      tape_rdata_r <= tape_mem[tape_raddr];
    end
  end

  // Loop stack memory: push at the fill level, pop reads the entry below it.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[scnt_r[SIDX_W-1:0]] <= cmd.addr;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[scnt_dec[SIDX_W-1:0]];
    end
  end

endmodule

// File: rtl/brainfuck_execution_core.sv
// ---------------------------------------------------------------------------
// brainfuck_execution_core
// Executes one program character per input word against a byte tape and a
// stack of open-loop addresses, giving one result word per input word.
// ---------------------------------------------------------------------------
//  Channel  Ports                        Word
//  input    in_valid  in_ready  in_data  instr_char, instr_addr, in_byte
//  result   out_valid out_ready out_data out_valid, out_byte, jump, jump_addr,
//                                        skipping, status
//
// Most commands need only S_RUN; > and < also pass through S_LOAD, as the
// cell under the new head is read from the tape memory, and a popping ]
// passes through S_POP for the loop stack memory read. The result register
// can be refilled in the cycle its word is taken; a result that waits stalls
// the back end, while the two-entry queue keeps taking input words until it
// holds two. After reset the tape is cleared cell by cell, with in_ready low.
// ---------------------------------------------------------------------------
module brainfuck_execution_core #(
  parameter int unsigned TAPE_CELLS  = 1024,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfe_pkg::bfe_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfe_pkg::bfe_out_t  out_data
);
  import bfe_pkg::*;

  logic           cmd_valid;
  bfe_cmd_t       cmd;
  bfe_bk_status_t bk;

  // Front end: classification and command queue.
  bfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .bk        (bk)
  );

  // Back end: execution and result register.
  bfe_back #(
    .TAPE_CELLS  (TAPE_CELLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .bk        (bk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/bfe_checker.sv
// ---------------------------------------------------------------------------
// bfe_checker
// Port-level assertions for the execution core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input bfe_pkg::bfe_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input bfe_pkg::bfe_out_t out_data
);
  import bfe_pkg::*;

  logic in_seen;

  // Input side is observed only; this keeps the ports in use.
  assign in_seen = in_valid && in_ready && (in_data.instr_char == in_data.instr_char);

  // A stalled result word holds.
  `BFE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")

  // An error or halted status carries no other information.
  `BFE_ASSERT(a_err_clean, out_valid && out_data.status != STAT_OK |-> !out_data.out_valid && !out_data.jump && !out_data.skipping && out_data.out_byte == 8'd0 && out_data.jump_addr == '0, "error word carries data")

  // Unused byte and address fields read as zero.
  `BFE_ASSERT(a_field_zero, out_valid |-> (out_data.out_valid || out_data.out_byte == 8'd0) && (out_data.jump || out_data.jump_addr == '0) && !(out_data.out_valid && out_data.jump), "field set without its flag")

  // Reset empties the result register and starts the tape clear.
  `BFE_ASSERT_RST(a_reset, !rst_n |=> !out_valid && !in_ready && !in_seen, "reset left the core active")

endmodule

bind brainfuck_execution_core bfe_checker u_bfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/tb_brainfuck_execution_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brainfuck_execution_core
// Drives program characters into the execution core through the valid/ready
// input channel and checks every result word against a cycle-free model of
// the tape, head, loop stack, skip counter and halt state kept in the bench.
// Short programs are run as a fetcher would run them, following each jump
// back to its opening bracket, mixed with noise words, deep nesting bursts
// and finally one randomly chosen error halt.
// ----------------------------------------------------------------------------
module tb_brainfuck_execution_core;
  import bfe_pkg::*;

  localparam int unsigned TAPE_CELLS  = 1024;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Expected behaviour of the core, advanced once per accepted input word.
  class bf_tape_tracker;
    logic [7:0]                tape [TAPE_CELLS];
    logic [PROG_ADDR_BITS-1:0] loop_addr [STACK_DEPTH];
    int                        head;
    int                        stack_cnt;
    int                        skip_depth;
    logic [1:0]                halt_code;
    bfe_out_t                  awaited_results [$];
    int                        errors;
    int                        checked;

    function new();
      foreach (tape[i]) tape[i] = 8'h00;
      foreach (loop_addr[i]) loop_addr[i] = '0;
      head       = 0;
      stack_cnt  = 0;
      skip_depth = 0;
      halt_code  = STAT_OK;
      errors     = 0;
      checked    = 0;
    endfunction

    function bfe_op_t classify(logic [7:0] ch);
      case (ch)
        CH_RIGHT: return OP_RIGHT;
        CH_LEFT:  return OP_LEFT;
        CH_INC:   return OP_INC;
        CH_DEC:   return OP_DEC;
        CH_OUT:   return OP_OUT;
        CH_IN:    return OP_IN;
        CH_OPEN:  return OP_OPEN;
        CH_CLOSE: return OP_CLOSE;
        default:  return OP_NONE;
      endcase
    endfunction

    // Executes one character and returns the result word it must produce.
    function bfe_out_t run_char(bfe_in_t w);
      bfe_out_t r;
      bfe_op_t  op;
      r  = '0;
      op = classify(w.instr_char);
      // Once halted, nothing changes until reset.
      if (halt_code != STAT_OK) begin
        r.status = STAT_HALTED;
        return r;
      end
      // Skip mode only counts brackets.
      if (skip_depth != 0) begin
        if (op == OP_OPEN) begin
          if (skip_depth >= STACK_DEPTH) begin
            halt_code = STAT_OVERFLOW;
            r.status  = STAT_OVERFLOW;
            return r;
          end
          skip_depth++;
        end else if (op == OP_CLOSE) begin
          skip_depth--;
        end
        r.skipping = (skip_depth != 0);
        return r;
      end
      case (op)
        OP_RIGHT: head = (head == TAPE_CELLS - 1) ? 0 : head + 1;
        OP_LEFT:  head = (head == 0) ? TAPE_CELLS - 1 : head - 1;
        OP_INC:   tape[head] = tape[head] + 8'd1;
        OP_DEC:   tape[head] = tape[head] - 8'd1;
        OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape[head];
        end
        OP_IN:    tape[head] = w.in_byte;
        OP_OPEN: begin
          if (tape[head] == 8'h00) begin
            skip_depth = 1;
            r.skipping = 1'b1;
          end else if (stack_cnt >= STACK_DEPTH) begin
            halt_code = STAT_OVERFLOW;
            r.status  = STAT_OVERFLOW;
          end else begin
            loop_addr[stack_cnt] = w.instr_addr;
            stack_cnt++;
          end
        end
        OP_CLOSE: begin
          if (stack_cnt == 0) begin
            halt_code = STAT_UNMATCHED;
            r.status  = STAT_UNMATCHED;
          end else begin
            stack_cnt--;
            r.jump      = 1'b1;
            r.jump_addr = loop_addr[stack_cnt];
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function bfe_out_t note_char(bfe_in_t w);
      bfe_out_t r;
      r = run_char(w);
      awaited_results.push_back(r);
      return r;
    endfunction

    function void check_result(bfe_out_t got);
      bfe_out_t want;
      checked++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result word %h arrived with none awaited.", got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
          got.jump !== want.jump || got.jump_addr !== want.jump_addr ||
          got.skipping !== want.skipping || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch on result %0d: expected out_valid=%b out_byte=%h jump=%b ",
                    "jump_addr=%h skipping=%b status=%0d, got %b %h %b %h %b %0d"},
                   checked, want.out_valid, want.out_byte, want.jump, want.jump_addr,
                   want.skipping, want.status, got.out_valid, got.out_byte, got.jump,
                   got.jump_addr, got.skipping, got.status);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bfe_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bfe_out_t out_data;

  bf_tape_tracker board = new();
  int       send_idle_pct = 10;
  int       recv_idle_pct = 56;
  int       words_sent = 0;
  int       commands_sent = 0;
  int       cycles = 0;
  string    halt_kind = "none";

  brainfuck_execution_core #(
    .TAPE_CELLS  (TAPE_CELLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result word is checked as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, board.awaited_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Presents one word, waits for its acceptance and returns its expected result.
  task automatic send_word(input bfe_in_t w, output bfe_out_t predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = board.note_char(w);
    words_sent++;
    if (board.classify(w.instr_char) != OP_NONE) commands_sent++;
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic [7:0] ch, input logic [11:0] addr,
                          input logic [7:0] data);
    bfe_in_t  w;
    bfe_out_t r;
    w.instr_char = ch;
    w.instr_addr = addr;
    w.in_byte    = data;
    send_word(w, r);
  endtask

  // Holds the input channel idle until every awaited result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.awaited_results.size() != 0) @(negedge clk);
  endtask

  // Replaces a bracket that would halt the core while errors are unwanted.
  function automatic logic [7:0] guard_char(logic [7:0] ch);
    bfe_op_t op;
    op = board.classify(ch);
    if (board.skip_depth != 0) begin
      if (op == OP_OPEN && board.skip_depth >= STACK_DEPTH) return CH_INC;
    end else begin
      if (op == OP_CLOSE && board.stack_cnt == 0) return CH_INC;
      if (op == OP_OPEN && board.tape[board.head] != 8'h00 &&
          board.stack_cnt >= STACK_DEPTH) return CH_INC;
    end
    return ch;
  endfunction

  // Builds a small program with balanced, mostly terminating loops.
  function automatic void build_program(ref logic [7:0] prog [$], input int depth);
    int n;
    int pick;
    n = $urandom_range(1, 4);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25 && depth < 3) begin
        if ($urandom_range(0, 1)) prog.push_back(CH_IN);
        prog.push_back(CH_OPEN);
        build_program(prog, depth + 1);
        prog.push_back(CH_DEC);
        prog.push_back(CH_CLOSE);
      end else if (pick < 30) begin
        prog.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 6))
          0: prog.push_back(CH_RIGHT);
          1: prog.push_back(CH_LEFT);
          2: prog.push_back(CH_INC);
          3: prog.push_back(CH_DEC);
          4: prog.push_back(CH_OUT);
          5: prog.push_back(CH_IN);
          default: prog.push_back(CH_INC);
        endcase
      end
    end
  endfunction

  // Runs a program the way a fetcher would, following every jump.
  task automatic run_program(input int target);
    logic [7:0]  prog [$];
    logic [11:0] base;
    logic [11:0] offset;
    int          pc;
    int          steps;
    bfe_in_t     w;
    bfe_out_t    r;
    build_program(prog, 0);
    base  = 12'($urandom);
    pc    = 0;
    steps = 0;
    while (pc < prog.size() && steps < 48 && commands_sent < target) begin
      w.instr_char = guard_char(prog[pc]);
      w.instr_addr = base + 12'(pc);
      w.in_byte    = 8'($urandom);
      send_word(w, r);
      steps++;
      if (r.jump) begin
        offset = r.jump_addr - base;
        pc     = int'(offset);
      end else begin
        pc++;
      end
    end
  endtask

  task automatic leave_skip();
    while (board.skip_depth != 0) send_cmd(CH_CLOSE, 12'($urandom), 8'($urandom));
  endtask

  // Fills the loop stack to the brim, then unwinds it.
  task automatic push_burst();
    int n;
    leave_skip();
    send_cmd(CH_IN, 12'($urandom), 8'($urandom_range(1, 255)));
    n = STACK_DEPTH - board.stack_cnt;
    repeat (n) send_cmd(CH_OPEN, 12'($urandom), 8'($urandom));
    repeat (n) send_cmd(CH_CLOSE, 12'($urandom), 8'($urandom));
  endtask

  // Skips a loop nested to the deepest level allowed, with other commands inside.
  task automatic skip_burst();
    leave_skip();
    send_cmd(CH_IN, 12'($urandom), 8'h00);
    repeat (STACK_DEPTH) begin
      if ($urandom_range(0, 3) == 0) send_cmd(CH_INC, 12'($urandom), 8'($urandom));
      send_cmd(CH_OPEN, 12'($urandom), 8'($urandom));
    end
    repeat (STACK_DEPTH) send_cmd(CH_CLOSE, 12'($urandom), 8'($urandom));
  endtask

  task automatic random_until(input int target);
    while (commands_sent < target) begin
      if ($urandom_range(0, 99) < 15)
        send_cmd(guard_char(8'($urandom)), 12'($urandom), 8'($urandom));
      else
        run_program(target);
    end
  endtask

  // Drives the core into one of its error halts, then checks it stays halted.
  task automatic provoke_halt();
    leave_skip();
    case ($urandom_range(0, 2))
      0: begin
        halt_kind = "unmatched bracket";
        while (board.stack_cnt > 0) send_cmd(CH_CLOSE, 12'($urandom), 8'($urandom));
        send_cmd(CH_CLOSE, 12'($urandom), 8'($urandom));
      end
      1: begin
        halt_kind = "stack overflow";
        send_cmd(CH_IN, 12'($urandom), 8'($urandom_range(1, 255)));
        while (board.halt_code == STAT_OK) send_cmd(CH_OPEN, 12'($urandom), 8'($urandom));
      end
      default: begin
        halt_kind = "skip overflow";
        send_cmd(CH_IN, 12'($urandom), 8'h00);
        while (board.halt_code == STAT_OK) send_cmd(CH_OPEN, 12'($urandom), 8'($urandom));
      end
    endcase
    repeat (6) send_cmd(8'($urandom), 12'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: cell and head wrap, output, input, nested skip and stacked loops.
    send_cmd(CH_OUT,   12'h001, 8'h00);
    send_cmd(CH_DEC,   12'h002, 8'h00);
    send_cmd(CH_OUT,   12'h003, 8'h00);
    send_cmd(CH_INC,   12'h004, 8'h00);
    send_cmd(CH_LEFT,  12'h005, 8'h00);
    send_cmd(CH_IN,    12'h006, 8'hFF);
    send_cmd(CH_OUT,   12'h007, 8'h00);
    send_cmd(CH_RIGHT, 12'h008, 8'h00);
    send_cmd(CH_OUT,   12'h009, 8'h00);
    send_cmd(CH_OPEN,  12'h00A, 8'h00);
    send_cmd(CH_OPEN,  12'h00B, 8'h00);
    send_cmd(CH_INC,   12'h00C, 8'h00);
    send_cmd(CH_CLOSE, 12'h00D, 8'h00);
    send_cmd(CH_CLOSE, 12'h00E, 8'h00);
    send_cmd(8'h41,    12'h00F, 8'hFF);
    send_cmd(8'h00,    12'h010, 8'h00);
    send_cmd(8'hFF,    12'h011, 8'hFF);
    send_cmd(CH_IN,    12'h012, 8'h01);
    send_cmd(CH_OPEN,  12'hFFF, 8'h00);
    send_cmd(CH_OPEN,  12'h000, 8'hFF);
    send_cmd(CH_CLOSE, 12'h013, 8'h00);
    send_cmd(CH_CLOSE, 12'h014, 8'h00);
    send_cmd(CH_OUT,   12'h015, 8'h00);

    // Slow receiver.
    push_burst();
    random_until(230);
    wait_drained();

    // Slow sender.
    send_idle_pct = 56;
    recv_idle_pct = 10;
    skip_burst();
    random_until(450);
    wait_drained();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_until(650);
    provoke_halt();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d commands) under three idling patterns in %0d cycles.",
             words_sent, commands_sent, cycles);
    $display("Checked %0d result words with %0d failures; the run ended in a %s halt.",
             board.checked, board.errors, halt_kind);
    if (board.errors == 0 && board.awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
